// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by rpn_min_max_add_evaluator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is high
`define ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// clocked check that also holds across reset
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, ck, rs, prop, msg)
`define ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

// File: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Widths, token codes and error codes of the RPN evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int FUNC_W      = 3;
  localparam int DEPTH_W     = 7;
  localparam int ERR_W       = 2;

  typedef logic [DATA_W-1:0] data_t;

  localparam logic [FUNC_W-1:0] FUNC_CONST = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_VAR   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MIN   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MAX   = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FEW  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd2;

endpackage

// File: rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/rpn_min_max_add_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_min_max_add_evaluator
// Postfix evaluator on an operand stack: push constant, push variable,
// add, min, max. Top two entries live in registers, the rest in a RAM.
// ----------------------------------------------------------------------------
// Output path: each token goes through the token register, then the result
//   register, which holds its value while out_ready is low.
// Throughput: one token per cycle while the output is not stalled, set by the
//   update of the two cached top entries and the read of the stack RAM on each pop.
// Reset: synchronous; empties the stack and clears valids and var_reg.
//   Stack RAM is not cleared, no clearing pass.
`include "assert_macros.svh"

module rpn_min_max_add_evaluator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic signed [63:0]          cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpn_pkg::FUNC_W-1:0]  func,
  input  logic signed [63:0]          operand,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [63:0]          top_value,
  output logic [rpn_pkg::DEPTH_W-1:0] depth,
  output logic [rpn_pkg::ERR_W-1:0]   error
);

  import rpn_pkg::*;

  // token register
  logic              in_vld;
  logic [FUNC_W-1:0] in_func;
  data_t             in_operand;
  logic              in_restart;

  // stack state: t = top, s = second, u = cached copy of third
  logic [CNT_W-1:0]  cnt, cnt_next;
  data_t             t_reg, t_next;
  data_t             s_reg, s_next;
  data_t             u_reg, u_next;
  logic              u_from_ram, u_from_ram_next;
  data_t             var_reg;

  logic              exec_fire;
  logic [CNT_W-1:0]  c0;
  logic [CNT_W-1:0]  c0_m2, c0_m4;
  data_t             u_cur, push_data, sum, min_val, max_val, bin_res;
  logic              a_lt_b, full, few, push_ok;
  logic [ERR_W-1:0]  err_next;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  data_t             ram_rdata;

  assign exec_fire = in_vld && (!out_valid || out_ready);
  assign in_ready  = !in_vld || exec_fire;

  assign c0      = in_restart ? '0 : cnt;
  assign c0_m2   = c0 - CNT_W'(2);
  assign c0_m4   = c0 - CNT_W'(4);
  assign u_cur   = u_from_ram ? ram_rdata : u_reg;
  assign full    = (c0 >= CNT_W'(STACK_DEPTH));
  assign few     = (c0 < CNT_W'(2));
  assign sum     = t_reg + s_reg;
  assign a_lt_b  = ($signed(t_reg) < $signed(s_reg));
  assign min_val = a_lt_b ? t_reg : s_reg;
  assign max_val = a_lt_b ? s_reg : t_reg;
  assign push_data = (in_func == FUNC_CONST) ? in_operand : var_reg;

  always_comb begin
    case (in_func)
      FUNC_MIN: bin_res = min_val;
      FUNC_MAX: bin_res = max_val;
      default:  bin_res = sum;
    endcase
  end

  always_comb begin
    cnt_next        = c0;
    t_next          = t_reg;
    s_next          = s_reg;
    u_next          = u_cur;
    u_from_ram_next = 1'b0;
    err_next        = ERR_OK;
    push_ok         = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = c0_m2[ADDR_W-1:0];
    ram_raddr       = c0_m4[ADDR_W-1:0];
    case (in_func) inside
      FUNC_CONST, FUNC_VAR: begin
        if (full) begin
          err_next = ERR_FULL;
        end else begin
          push_ok  = 1'b1;
          cnt_next = c0 + CNT_W'(1);
          t_next   = push_data;
          s_next   = t_reg;
          u_next   = s_reg;
          // old second drops into the RAM
          ram_we   = exec_fire && !few;
        end
      end
      FUNC_ADD, FUNC_MIN, FUNC_MAX: begin
        if (few) begin
          err_next = ERR_FEW;
        end else begin
          cnt_next        = c0 - CNT_W'(1);
          t_next          = bin_res;
          s_next          = u_cur;
          // refill the third slot from the RAM, ready next cycle
          ram_re          = exec_fire;
          u_from_ram_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (s_reg),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld     <= 1'b0;
      out_valid  <= 1'b0;
      cnt        <= '0;
      u_from_ram <= 1'b0;
      var_reg    <= '0;
    end else begin
      if (cfg_wr_en) begin
        var_reg <= cfg_wr_data;
      end
      if (in_ready) begin
        in_vld <= in_valid;
      end
      if (exec_fire) begin
        out_valid  <= 1'b1;
        cnt        <= cnt_next;
        u_from_ram <= u_from_ram_next;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        u_from_ram <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_func    <= func;
      in_operand <= operand;
      in_restart <= restart;
    end
    if (exec_fire) begin
      t_reg     <= t_next;
      s_reg     <= s_next;
      u_reg     <= u_next;
      top_value <= (cnt_next == '0) ? '0 : t_next;
      depth     <= DEPTH_W'(cnt_next);
      error     <= err_next;
    end else begin
      // hold the RAM read data before the read port moves on
      u_reg <= u_cur;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst, cnt <= CNT_W'(STACK_DEPTH), "stack count above depth")
  `ASSERT_CLK(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "not ready with empty output")
  `ASSERT_CLK(a_full_depth, clk, rst,
    (out_valid && error == ERR_FULL) |-> (depth == DEPTH_W'(STACK_DEPTH)), "full error below depth")
  `ASSERT_CLK(a_push_count, clk, rst,
    (exec_fire && push_ok) |=> (cnt == $past(c0) + CNT_W'(1)), "push did not grow the stack")
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!out_valid && !in_vld), "valid after reset")

endmodule
